// File: sv/wvg_pkg.sv
// Types, register indexes and constants shared by the waypoint guidance block.
package wvg_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH_TOL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_RATE_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_HEADING   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_COUNT = 3'd6;

  localparam logic [30:0] SPEED_LIMIT_RST    = 31'd32768;
  localparam logic [30:0] REACH_TOL_RST      = 31'd13107;
  localparam logic [15:0] POSITION_GAIN_RST  = 16'd256;
  localparam logic [15:0] YAW_GAIN_RST       = 16'd64;
  localparam logic [14:0] YAW_RATE_LIMIT_RST = 15'd1043;
  localparam logic [6:0]  WAYPOINT_COUNT_RST = 7'd1;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic [1:0] PH_ALIGN     = 2'd0;
  localparam logic [1:0] PH_TRANSLATE = 2'd1;
  localparam logic [1:0] PH_DESCEND   = 2'd2;

  localparam logic [63:0] LEG_TURN_SQ = 64'd10738729;
  localparam logic [63:0] LEG_SKIP_SQ = 64'd2683044;
  localparam logic signed [15:0] YAW_CLOSE = 16'sd1043;

  localparam logic [17:0] CORDIC_TAB [16] = '{
    18'd131072, 18'd77376, 18'd40884, 18'd20753, 18'd10417, 18'd5213, 18'd2607, 18'd1304,
    18'd652, 18'd326, 18'd163, 18'd81, 18'd41, 18'd20, 18'd10, 18'd5
  };

  typedef struct packed {
    logic        kind;
    logic [5:0]  slot;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [15:0] heading;
  } in_t;

  typedef struct packed {
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [15:0] turn_rate;
    logic [6:0]  target_index;
    logic [1:0]  phase;
  } out_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_RD_CUR, ST_RD_PREV, ST_LEG, ST_MUL_DX, ST_MUL_DY, ST_HSUM, ST_LEG_SEL,
    ST_NORM, ST_PREROT, ST_CORDIC, ST_ANGLE, ST_YAW_ERR, ST_MUL_YAW, ST_MUL_E0, ST_MUL_E1,
    ST_MUL_E2, ST_MUL_TOL, ST_REACH, ST_MUL_V0, ST_MUL_V1, ST_MUL_V2, ST_VMAX, ST_SHIFT,
    ST_MUL_W0, ST_MUL_W1, ST_MUL_W2, ST_MUL_SPD, ST_LIMIT, ST_SQRT, ST_MUL_DIV, ST_DIV_LOAD,
    ST_DIV, ST_EMIT
  } state_e;

endpackage

// File: sv/waypoint_velocity_guidance.sv
// Waypoint guidance top level: waypoint table, sequencer and shared multiplier datapath.
// A tick past the last waypoint goes straight to the result; a tick on a leg walks the
// read, leg, yaw and reach states, plus the normalize and CORDIC steps when the leg
// heading is computed, plus the velocity states for a translate result, plus the square
// root and three divide passes when the speed limit bites. This walk comes from the
// sequencer, which takes every product through one registered 34x32 multiplier, the
// one-bit-a-cycle square root and restoring divider, and the single read port of the
// waypoint table. The table has no reset; a slot must be loaded before a tick reads it.
module waypoint_velocity_guidance #(
  parameter int MAX_WAYPOINTS = wvg_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wvg_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wvg_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wvg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import wvg_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WAYPOINTS);

  state_e state_q, state_d;

  logic [30:0] speed_q, tol_q;
  logic [15:0] pgain_q, ygain_q;
  logic [14:0] yrl_q;
  logic        hold_q;
  logic [6:0]  wp_count_q;

  logic [95:0] mem_q [MAX_WAYPOINTS];
  logic [95:0] rd_q;
  logic [ADDR_W-1:0] rd_addr;

  in_t                in_q;
  logic signed [31:0] origin_q [3];
  logic               origin_vld_q;
  logic signed [32:0] pos_q [3];
  logic [95:0]        cur_q;
  logic signed [33:0] e_q [3];
  logic signed [32:0] dx_q, dy_q;
  logic [33:0]        mul_a;
  logic [31:0]        mul_b;
  logic [65:0]        mul_q;
  logic [63:0]        h_q, se_q, s_q;
  logic signed [44:0] x_q, y_q;
  logic signed [21:0] z_q;
  logic [5:0]         cnt_q;
  logic signed [15:0] target_q, err_q;
  logic [14:0]        tmag_q;
  logic [41:0]        vm_q [3];
  logic [41:0]        mx_q;
  logic               kflag_q;
  logic [63:0]        sq_n_q, sq_r_q, sq_b_q;
  logic [63:0]        dvd_q;
  logic [31:0]        rem_q;
  logic [1:0]         div_i_q;
  logic [31:0]        vel_q [3];
  logic [15:0]        turn_q;
  logic [1:0]         phase_q;
  logic [6:0]         idx_q;
  logic               pr_q, yr_q;
  logic               out_valid_q;
  out_t               out_q;

  logic        in_acc, cfg_acc, out_load;
  logic [6:0]  cnt_eff;
  logic        finished;
  logic [33:0] e_mag [3];
  logic [32:0] dx_mag, dy_mag;
  logic        far_leg, far_err;
  logic signed [16:0] err_ext;
  logic [16:0] err_mag;
  logic [23:0] yq;
  logic [15:0] yaw_turn;
  logic [41:0] vm_new;
  logic [44:0] xm, ym, xy_max;
  logic signed [44:0] sh_x, sh_y;
  logic signed [21:0] tab_v, z_rnd;
  logic        pr_new, yr_new, go_align, go_trans, speed_ok;
  logic [63:0] sq_t;
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic [63:0] dvd_next;
  logic [31:0] rem_next;

  function automatic logic [33:0] mag34(logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [44:0] mag45(logic signed [44:0] v);
    return v[44] ? 45'(-v) : 45'(v);
  endfunction

  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  assign cnt_eff  = (int'(wp_count_q) > MAX_WAYPOINTS) ? 7'(MAX_WAYPOINTS) : wp_count_q;
  assign finished = idx_q >= cnt_eff;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_mag[i] = mag34(e_q[i]);
    end
  end

  assign far_err = (e_mag[0][33:31] != 3'd0) || (e_mag[1][33:31] != 3'd0) ||
                   (e_mag[2][33:31] != 3'd0);
  assign dx_mag  = mag33(dx_q);
  assign dy_mag  = mag33(dy_q);
  assign far_leg = (dx_mag[32:31] != 2'd0) || (dy_mag[32:31] != 2'd0);

  assign err_ext  = 17'(err_q);
  assign err_mag  = err_q[15] ? 17'(-err_ext) : 17'(err_ext);
  assign yq       = 24'((mul_q[32:0] + 33'd128) >> 8);
  assign yaw_turn = err_q[15] ? 16'(16'd0 - {1'b0, tmag_q}) : {1'b0, tmag_q};
  assign vm_new   = 42'((51'(mul_q[49:0]) + 51'd128) >> 8);

  assign xm     = mag45(x_q);
  assign ym     = mag45(y_q);
  assign xy_max = (xm > ym) ? xm : ym;
  assign sh_x   = x_q >>> cnt_q[3:0];
  assign sh_y   = y_q >>> cnt_q[3:0];
  assign tab_v  = 22'(CORDIC_TAB[cnt_q[3:0]]);
  assign z_rnd  = (z_q + 22'sd8) >>> 4;

  assign pr_new   = pr_q || (!far_err && (se_q < mul_q[63:0]));
  assign yr_new   = yr_q || (idx_q == 7'd0) || (!far_leg && (h_q < LEG_SKIP_SQ)) ||
                    ((err_q > -YAW_CLOSE) && (err_q < YAW_CLOSE));
  assign go_align = !yr_new && !hold_q;
  assign go_trans = !go_align && !pr_new;
  assign speed_ok = !kflag_q && (s_q <= mul_q[63:0]);

  assign sq_t = sq_r_q + sq_b_q;

  assign rem_sh   = {rem_q, dvd_q[63]};
  assign rem_ge   = rem_sh >= {1'b0, sq_r_q[31:0]};
  assign rem_next = rem_ge ? 32'(rem_sh - {1'b0, sq_r_q[31:0]}) : rem_sh[31:0];
  assign dvd_next = {dvd_q[62:0], rem_ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.kind == KIND_TICK) begin
          state_d = finished ? ST_EMIT : ST_RD_CUR;
        end
      end
      ST_RD_CUR:  state_d = ST_RD_PREV;
      ST_RD_PREV: state_d = ST_LEG;
      ST_LEG:     state_d = ST_MUL_DX;
      ST_MUL_DX:  state_d = ST_MUL_DY;
      ST_MUL_DY:  state_d = ST_HSUM;
      ST_HSUM:    state_d = ST_LEG_SEL;
      ST_LEG_SEL: begin
        if (idx_q != 7'd0 && (far_leg || h_q > LEG_TURN_SQ)) begin
          state_d = ST_NORM;
        end else begin
          state_d = ST_YAW_ERR;
        end
      end
      ST_NORM:    if (xy_max[44:40] != 5'd0) state_d = ST_PREROT;
      ST_PREROT:  state_d = ST_CORDIC;
      ST_CORDIC:  if (cnt_q[3:0] == 4'd15) state_d = ST_ANGLE;
      ST_ANGLE:   state_d = ST_YAW_ERR;
      ST_YAW_ERR: state_d = ST_MUL_YAW;
      ST_MUL_YAW: state_d = ST_MUL_E0;
      ST_MUL_E0:  state_d = ST_MUL_E1;
      ST_MUL_E1:  state_d = ST_MUL_E2;
      ST_MUL_E2:  state_d = ST_MUL_TOL;
      ST_MUL_TOL: state_d = ST_REACH;
      ST_REACH: begin
        if (go_align) begin
          state_d = ST_EMIT;
        end else if (go_trans) begin
          state_d = ST_MUL_V0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL_V0:  state_d = ST_MUL_V1;
      ST_MUL_V1:  state_d = ST_MUL_V2;
      ST_MUL_V2:  state_d = ST_VMAX;
      ST_VMAX:    state_d = ST_SHIFT;
      ST_SHIFT:   if (mx_q[41:31] == 11'd0) state_d = ST_MUL_W0;
      ST_MUL_W0:  state_d = ST_MUL_W1;
      ST_MUL_W1:  state_d = ST_MUL_W2;
      ST_MUL_W2:  state_d = ST_MUL_SPD;
      ST_MUL_SPD: state_d = ST_LIMIT;
      ST_LIMIT:   state_d = speed_ok ? ST_EMIT : ST_SQRT;
      ST_SQRT:    if (cnt_q[4:0] == 5'd31) state_d = ST_MUL_DIV;
      ST_MUL_DIV: state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == 6'd63) begin
          state_d = (div_i_q == 2'd2) ? ST_EMIT : ST_MUL_DIV;
        end
      end
      ST_EMIT:    if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    rd_addr    = (state_q == ST_RD_CUR) ? ADDR_W'(idx_q) : ADDR_W'(idx_q - 7'd1);
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ST_MUL_DX: begin
        mul_a = 34'(dx_mag);
        mul_b = dx_mag[31:0];
      end
      ST_MUL_DY: begin
        mul_a = 34'(dy_mag);
        mul_b = dy_mag[31:0];
      end
      ST_MUL_YAW: begin
        mul_a = 34'(err_mag);
        mul_b = 32'(ygain_q);
      end
      ST_MUL_E0, ST_MUL_E1, ST_MUL_E2: begin
        mul_a = e_mag[2'(state_q - ST_MUL_E0)];
        mul_b = e_mag[2'(state_q - ST_MUL_E0)][31:0];
      end
      ST_MUL_TOL: begin
        mul_a = 34'(tol_q);
        mul_b = 32'(tol_q);
      end
      ST_MUL_V0, ST_MUL_V1, ST_MUL_V2: begin
        mul_a = e_mag[2'(state_q - ST_MUL_V0)];
        mul_b = 32'(pgain_q);
      end
      ST_MUL_W0, ST_MUL_W1, ST_MUL_W2: begin
        mul_a = vm_q[2'(state_q - ST_MUL_W0)][33:0];
        mul_b = vm_q[2'(state_q - ST_MUL_W0)][31:0];
      end
      ST_MUL_SPD: begin
        mul_a = 34'(speed_q);
        mul_b = 32'(speed_q);
      end
      ST_MUL_DIV: begin
        mul_a = vm_q[div_i_q][33:0];
        mul_b = 32'(speed_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.kind == KIND_LOAD && int'(in_data_i.slot) < MAX_WAYPOINTS) begin
      mem_q[ADDR_W'(in_data_i.slot)] <= {in_data_i.coord_z, in_data_i.coord_y,
                                         in_data_i.coord_x};
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      speed_q      <= SPEED_LIMIT_RST;
      tol_q        <= REACH_TOL_RST;
      pgain_q      <= POSITION_GAIN_RST;
      ygain_q      <= YAW_GAIN_RST;
      yrl_q        <= YAW_RATE_LIMIT_RST;
      hold_q       <= 1'b0;
      wp_count_q   <= WAYPOINT_COUNT_RST;
      origin_vld_q <= 1'b0;
      idx_q        <= '0;
      pr_q         <= 1'b0;
      yr_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_SPEED_LIMIT:    speed_q    <= cfg_data_i[30:0];
          CFG_REACH_TOL:      tol_q      <= cfg_data_i[30:0];
          CFG_POSITION_GAIN:  pgain_q    <= cfg_data_i[15:0];
          CFG_YAW_GAIN:       ygain_q    <= cfg_data_i[15:0];
          CFG_YAW_RATE_LIMIT: yrl_q      <= cfg_data_i[14:0];
          CFG_HOLD_HEADING:   hold_q     <= cfg_data_i[0];
          CFG_WAYPOINT_COUNT: wp_count_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (in_acc && in_data_i.kind == KIND_TICK) begin
        origin_vld_q <= 1'b1;
      end
      if (state_q == ST_REACH) begin
        if (!go_align && !go_trans) begin
          idx_q <= idx_q + 7'd1;
          pr_q  <= 1'b0;
          yr_q  <= 1'b0;
        end else begin
          pr_q <= pr_new;
          yr_q <= yr_new;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (out_load) begin
      out_q.vel_x        <= vel_q[0];
      out_q.vel_y        <= vel_q[1];
      out_q.vel_z        <= vel_q[2];
      out_q.turn_rate    <= turn_q;
      out_q.target_index <= idx_q;
      out_q.phase        <= phase_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          in_q <= in_data_i;
        end
        if (in_acc && in_data_i.kind == KIND_TICK) begin
          if (!origin_vld_q) begin
            origin_q[0] <= in_data_i.coord_x;
            origin_q[1] <= in_data_i.coord_y;
            origin_q[2] <= in_data_i.coord_z;
            for (int i = 0; i < 3; i++) begin
              pos_q[i] <= '0;
            end
          end else begin
            pos_q[0] <= 33'($signed(in_data_i.coord_x)) - 33'(origin_q[0]);
            pos_q[1] <= 33'($signed(in_data_i.coord_y)) - 33'(origin_q[1]);
            pos_q[2] <= 33'($signed(in_data_i.coord_z)) - 33'(origin_q[2]);
          end
          vel_q[0] <= '0;
          vel_q[1] <= '0;
          vel_q[2] <= 32'd0 - {1'b0, speed_q};
          turn_q   <= '0;
          phase_q  <= PH_DESCEND;
        end
      end
      ST_RD_PREV: begin
        cur_q <= rd_q;
        e_q[0] <= 34'($signed(rd_q[31:0])) - 34'(pos_q[0]);
        e_q[1] <= 34'($signed(rd_q[63:32])) - 34'(pos_q[1]);
        e_q[2] <= 34'($signed(rd_q[95:64])) - 34'(pos_q[2]);
      end
      ST_LEG: begin
        if (idx_q == 7'd0) begin
          dx_q <= '0;
          dy_q <= '0;
        end else begin
          dx_q <= 33'($signed(cur_q[31:0])) - 33'($signed(rd_q[31:0]));
          dy_q <= 33'($signed(cur_q[63:32])) - 33'($signed(rd_q[63:32]));
        end
      end
      ST_MUL_DY: h_q <= mul_q[63:0];
      ST_HSUM:   h_q <= h_q + mul_q[63:0];
      ST_LEG_SEL: begin
        x_q      <= 45'(dx_q);
        y_q      <= 45'(dy_q);
        target_q <= $signed(in_q.heading);
      end
      ST_NORM: begin
        if (xy_max[44:40] == 5'd0) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end
      end
      ST_PREROT: begin
        cnt_q <= '0;
        if (x_q < 0) begin
          if (y_q >= 0) begin
            x_q <= y_q;
            y_q <= -x_q;
            z_q <= 22'sd262144;
          end else begin
            x_q <= -y_q;
            y_q <= x_q;
            z_q <= -22'sd262144;
          end
        end else begin
          z_q <= '0;
        end
      end
      ST_CORDIC: begin
        cnt_q <= cnt_q + 6'd1;
        if (y_q > 0) begin
          x_q <= x_q + sh_y;
          y_q <= y_q - sh_x;
          z_q <= z_q + tab_v;
        end else begin
          x_q <= x_q - sh_y;
          y_q <= y_q + sh_x;
          z_q <= z_q - tab_v;
        end
      end
      ST_ANGLE:   target_q <= z_rnd[15:0];
      ST_YAW_ERR: err_q <= target_q - $signed(in_q.heading);
      ST_MUL_E0:  tmag_q <= (yq > 24'(yrl_q)) ? yrl_q : yq[14:0];
      ST_MUL_E1:  se_q <= mul_q[63:0];
      ST_MUL_E2, ST_MUL_TOL: se_q <= se_q + mul_q[63:0];
      ST_REACH: begin
        turn_q <= hold_q ? '0 : yaw_turn;
        if (go_align) begin
          vel_q[0] <= '0;
          vel_q[1] <= '0;
          vel_q[2] <= '0;
          phase_q  <= PH_ALIGN;
        end else begin
          phase_q <= PH_TRANSLATE;
        end
      end
      ST_MUL_V1: begin
        vm_q[0] <= vm_new;
        mx_q    <= vm_new;
      end
      ST_MUL_V2: begin
        vm_q[1] <= vm_new;
        mx_q    <= (vm_new > mx_q) ? vm_new : mx_q;
      end
      ST_VMAX: begin
        vm_q[2] <= vm_new;
        mx_q    <= (vm_new > mx_q) ? vm_new : mx_q;
        kflag_q <= 1'b0;
      end
      ST_SHIFT: begin
        if (mx_q[41:31] != 11'd0) begin
          mx_q    <= mx_q >> 1;
          kflag_q <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            vm_q[i] <= vm_q[i] >> 1;
          end
        end
      end
      ST_MUL_W1: s_q <= mul_q[63:0];
      ST_MUL_W2, ST_MUL_SPD: s_q <= s_q + mul_q[63:0];
      ST_LIMIT: begin
        for (int i = 0; i < 3; i++) begin
          vel_q[i] <= e_q[i][33] ? 32'd0 - vm_q[i][31:0] : vm_q[i][31:0];
        end
        sq_n_q  <= s_q;
        sq_r_q  <= '0;
        sq_b_q  <= 64'd1 << 62;
        cnt_q   <= '0;
        div_i_q <= '0;
      end
      ST_SQRT: begin
        cnt_q  <= cnt_q + 6'd1;
        sq_b_q <= sq_b_q >> 2;
        if (sq_n_q >= sq_t) begin
          sq_n_q <= sq_n_q - sq_t;
          sq_r_q <= (sq_r_q >> 1) + sq_b_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
      end
      ST_DIV_LOAD: begin
        dvd_q <= mul_q[63:0];
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        cnt_q <= cnt_q + 6'd1;
        dvd_q <= dvd_next;
        rem_q <= rem_next;
        if (cnt_q == 6'd63) begin
          vel_q[div_i_q] <= e_q[div_i_q][33] ? 32'd0 - dvd_next[31:0] : dvd_next[31:0];
          div_i_q        <= div_i_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(idx_q) <= MAX_WAYPOINTS)
    else $error("waypoint index beyond table");

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.phase == PH_ALIGN || out_data_o.phase == PH_TRANSLATE ||
                     out_data_o.phase == PH_DESCEND))
    else $error("result carries unknown phase");

  a_descend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.phase == PH_DESCEND |->
      out_data_o.turn_rate == 16'd0 && out_data_o.vel_x == 32'd0 &&
      out_data_o.vel_y == 32'd0)
    else $error("descent result has lateral motion");

  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.phase == PH_ALIGN |->
      out_data_o.vel_x == 32'd0 && out_data_o.vel_y == 32'd0 && out_data_o.vel_z == 32'd0)
    else $error("aligning result has velocity");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && out_valid_q && !out_ready_i |=> state_q == ST_EMIT)
    else $error("result dropped while output busy");

endmodule

// File: tb/waypoint_velocity_guidance_checker.sv
// Checker for the waypoint guidance block: predicts each command and compares it on the output.
`timescale 1ns / 1ps
module waypoint_velocity_guidance_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  wvg_pkg::in_t                  in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  wvg_pkg::out_t                 out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [wvg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import wvg_pkg::*;

  localparam longint unsigned LIM31 = 64'd1 << 31;
  localparam int NWP = MAX_WAYPOINTS_DEF;

  longint wp_x [NWP];
  longint wp_y [NWP];
  longint wp_z [NWP];
  longint org [3];
  bit     org_ok;
  int     cur_idx;
  bit     pos_hit;
  bit     yaw_hit;
  longint spd, tol, pgain, ygain, yrl, hold, wcount;
  out_t   expected_cmds [$];
  int     fails;

  function automatic longint unsigned absv(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic int wrap16(input longint v);
    logic [15:0] b;
    b = v[15:0];
    return int'($signed(b));
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned n_in);
    longint unsigned r, b, n;
    n = n_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int leg_angle(input longint x_in, input longint y_in);
    longint x, y, z, t;
    longint unsigned m;
    int i;
    x = x_in;
    y = y_in;
    z = 0;
    m = absv(x) > absv(y) ? absv(x) : absv(y);
    while (m < (64'd1 << 40)) begin
      x = x * 2;
      y = y * 2;
      m = m << 1;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 262144;
      end else begin
        t = x; x = -y; y = t; z = -262144;
      end
    end
    for (i = 0; i < 16; i++) begin
      t = x;
      if (y > 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + longint'(CORDIC_TAB[i]);
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - longint'(CORDIC_TAB[i]);
      end
    end
    return wrap16((z + 8) >>> 4);
  endfunction

  function automatic longint turn_cmd(input int err);
    longint p;
    longint unsigned q;
    p = ygain * longint'(err);
    q = (absv(p) + 128) >> 8;
    if (q > yrl) q = yrl;
    return p < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void speed_cmd(input longint e [3], output longint o [3]);
    longint v [3];
    longint w [3];
    longint p;
    longint unsigned mx, s, n, q;
    int i, k;
    mx = 0;
    s = 0;
    k = 0;
    for (i = 0; i < 3; i++) begin
      p = pgain * e[i];
      q = (absv(p) + 128) >> 8;
      v[i] = p < 0 ? -longint'(q) : longint'(q);
      if (absv(v[i]) > mx) mx = absv(v[i]);
    end
    while ((mx >> k) >= LIM31) k++;
    for (i = 0; i < 3; i++) begin
      q = absv(v[i]) >> k;
      w[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      s = s + q * q;
    end
    if (k == 0 && s <= longint'(spd * spd)) begin
      o = v;
      return;
    end
    n = isqrt(s);
    for (i = 0; i < 3; i++) o[i] = (w[i] * spd) / longint'(n);
  endfunction

  task automatic predict_command(input in_t it);
    longint c [3];
    longint pos [3];
    longint e [3];
    longint vel [3];
    longint turn, dx, dy;
    longint unsigned h, se;
    int head, target, err, idx, count, i;
    bit far_leg, far_err;
    logic [1:0] ph;
    out_t r;
    c[0] = longint'($signed(it.coord_x));
    c[1] = longint'($signed(it.coord_y));
    c[2] = longint'($signed(it.coord_z));
    if (it.kind == KIND_LOAD) begin
      wp_x[it.slot] = c[0];
      wp_y[it.slot] = c[1];
      wp_z[it.slot] = c[2];
      return;
    end
    head = int'($signed(it.heading));
    if (!org_ok) begin
      org = c;
      org_ok = 1'b1;
    end
    for (i = 0; i < 3; i++) pos[i] = c[i] - org[i];
    vel = '{0, 0, 0};
    turn = 0;
    h = 0;
    se = 0;
    far_leg = 1'b0;
    far_err = 1'b0;
    idx = cur_idx;
    count = wcount > NWP ? NWP : int'(wcount);
    if (idx >= count) begin
      vel[2] = -spd;
      ph = PH_DESCEND;
    end else begin
      e[0] = wp_x[idx] - pos[0];
      e[1] = wp_y[idx] - pos[1];
      e[2] = wp_z[idx] - pos[2];
      target = head;
      if (idx > 0) begin
        dx = wp_x[idx] - wp_x[idx-1];
        dy = wp_y[idx] - wp_y[idx-1];
        far_leg = absv(dx) >= LIM31 || absv(dy) >= LIM31;
        if (!far_leg) h = absv(dx) * absv(dx) + absv(dy) * absv(dy);
        if (far_leg || h > LEG_TURN_SQ) target = leg_angle(dx, dy);
      end
      err = wrap16(longint'(target - head));
      if (!pos_hit) begin
        for (i = 0; i < 3; i++) begin
          if (absv(e[i]) >= LIM31) far_err = 1'b1;
          else se = se + absv(e[i]) * absv(e[i]);
        end
        pos_hit = !far_err && se < longint'(tol * tol);
      end
      if (!yaw_hit)
        yaw_hit = idx == 0 || (!far_leg && h < LEG_SKIP_SQ) ||
                  (err > -int'(YAW_CLOSE) && err < int'(YAW_CLOSE));
      if (!yaw_hit && hold == 0) begin
        turn = turn_cmd(err);
        ph = PH_ALIGN;
      end else if (!pos_hit) begin
        turn = hold != 0 ? 0 : turn_cmd(err);
        speed_cmd(e, vel);
        ph = PH_TRANSLATE;
      end else begin
        cur_idx = idx + 1;
        pos_hit = 1'b0;
        yaw_hit = 1'b0;
        return;
      end
    end
    r.vel_x = vel[0][31:0];
    r.vel_y = vel[1][31:0];
    r.vel_z = vel[2][31:0];
    r.turn_rate = turn[15:0];
    r.target_index = idx[6:0];
    r.phase = ph;
    expected_cmds.insert(expected_cmds.size(), r);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NWP; i++) begin
        wp_x[i] = 0;
        wp_y[i] = 0;
        wp_z[i] = 0;
      end
      org = '{0, 0, 0};
      org_ok = 1'b0;
      cur_idx = 0;
      pos_hit = 1'b0;
      yaw_hit = 1'b0;
      spd = SPEED_LIMIT_RST;
      tol = REACH_TOL_RST;
      pgain = POSITION_GAIN_RST;
      ygain = YAW_GAIN_RST;
      yrl = YAW_RATE_LIMIT_RST;
      hold = 0;
      wcount = WAYPOINT_COUNT_RST;
      expected_cmds.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_cmds.size() == 0) begin
          report("unexpected transaction", longint'(out_data_i.target_index), 0);
        end else begin
          want = expected_cmds.pop_front();
          if (out_data_i.vel_x !== want.vel_x) report("vel_x", out_data_i.vel_x, want.vel_x);
          if (out_data_i.vel_y !== want.vel_y) report("vel_y", out_data_i.vel_y, want.vel_y);
          if (out_data_i.vel_z !== want.vel_z) report("vel_z", out_data_i.vel_z, want.vel_z);
          if (out_data_i.turn_rate !== want.turn_rate)
            report("turn_rate", out_data_i.turn_rate, want.turn_rate);
          if (out_data_i.target_index !== want.target_index)
            report("target_index", out_data_i.target_index, want.target_index);
          if (out_data_i.phase !== want.phase) report("phase", out_data_i.phase, want.phase);
        end
      end
      if (in_valid_i && in_ready_i) predict_command(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SPEED_LIMIT:    spd = cfg_data_i[30:0];
          CFG_REACH_TOL:      tol = cfg_data_i[30:0];
          CFG_POSITION_GAIN:  pgain = cfg_data_i[15:0];
          CFG_YAW_GAIN:       ygain = cfg_data_i[15:0];
          CFG_YAW_RATE_LIMIT: yrl = cfg_data_i[14:0];
          CFG_HOLD_HEADING:   hold = cfg_data_i[0];
          CFG_WAYPOINT_COUNT: wcount = cfg_data_i[6:0];
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o <= expected_cmds.size();
    end
  end

endmodule

// File: tb/waypoint_velocity_guidance_test.sv
// Top of the waypoint guidance testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module waypoint_velocity_guidance_test;
  import wvg_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int SETTLE = 400;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  int                   fail_count;
  int                   pending;

  int  snd_idle = 8;
  int  rcv_idle = 64;
  int  cycles = 0;
  int  tx [64];
  int  ty [64];
  int  tz [64];
  bit  loaded [64];
  bit  org_set = 1'b0;
  int  ox, oy, oz;
  int  last_idx = 0;
  int  tol_now = 13107;
  int  cnt_now = 1;
  int  n_rand = 0;

  waypoint_velocity_guidance dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  waypoint_velocity_guidance_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("waypoint_velocity_guidance regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
    if (out_valid && out_ready) last_idx <= out_data.target_index;
  end

  task automatic send_item(input in_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load(input int s, input int x, input int y, input int z);
    in_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.slot = s[5:0];
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.heading = 16'($urandom);
    tx[s] = x;
    ty[s] = y;
    tz[s] = z;
    loaded[s] = 1'b1;
    send_item(it);
  endtask

  task automatic tick(input int x, input int y, input int z, input int hd);
    in_t it;
    it = '0;
    it.kind = KIND_TICK;
    it.slot = 6'($urandom);
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.heading = hd[15:0];
    if (!org_set) begin
      ox = x;
      oy = y;
      oz = z;
      org_set = 1'b1;
    end
    send_item(it);
  endtask

  task automatic load_chain(input int s);
    int bx, by, bz, d;
    bx = 0;
    by = 0;
    bz = 0;
    if (s > 0 && loaded[s-1]) begin
      bx = tx[s-1];
      by = ty[s-1];
      bz = tz[s-1];
    end else if (s == 0) begin
      bx = int'($urandom_range(0, 2000000)) - 1000000;
      by = int'($urandom_range(0, 2000000)) - 1000000;
    end
    d = $urandom_range(9) < 2 ? $urandom_range(0, 3500) : $urandom_range(3500, 300000);
    case ($urandom_range(3))
      0: bx = bx + d;
      1: bx = bx - d;
      2: by = by + d;
      default: by = by - d;
    endcase
    bz = bz + int'($urandom_range(0, 100000)) - 50000;
    load(s, bx, by, bz);
  endtask

  function automatic int leg_guess(input int g);
    longint dx, dy, ax, ay;
    if (g == 0) return int'($urandom_range(0, 65535)) - 32768;
    dx = longint'(tx[g]) - longint'(tx[g-1]);
    dy = longint'(ty[g]) - longint'(ty[g-1]);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= ay) return dx >= 0 ? 0 : -32768;
    return dy >= 0 ? 16384 : -16384;
  endfunction

  task automatic aimed_tick();
    int g, r, hd;
    g = ($urandom_range(9) < 6) ? last_idx : last_idx + 1;
    if (g > 63) g = 63;
    if (!loaded[g]) g = 0;
    r = tol_now / 2;
    if (r > 200000) r = 200000;
    if ($urandom_range(9) < 3) r = 500000;
    hd = leg_guess(g);
    if ($urandom_range(9) < 7) hd = hd + int'($urandom_range(0, 1200)) - 600;
    else hd = int'($urandom_range(0, 65535));
    tick(ox + tx[g] + int'($urandom_range(0, 2 * r)) - r,
         oy + ty[g] + int'($urandom_range(0, 2 * r)) - r,
         oz + tz[g] + int'($urandom_range(0, 2 * r)) - r, hd);
  endtask

  task automatic random_item();
    int sel, top;
    sel = $urandom_range(99);
    if (sel < 20) begin
      top = cnt_now + 1 > 63 ? 63 : cnt_now + 1;
      if ($urandom_range(99) < 85) load_chain($urandom_range(0, top));
      else load($urandom_range(0, 63), $urandom, $urandom, $urandom);
    end else if (sel < 35 || !org_set) begin
      tick($urandom, $urandom, $urandom, $urandom);
    end else begin
      aimed_tick();
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input int ph);
    logic [31:0] spd, tol, pg, yg, yrl, hold, cnt;
    case (ph)
      0: begin
        spd = SPEED_LIMIT_RST; tol = REACH_TOL_RST; pg = POSITION_GAIN_RST;
        yg = YAW_GAIN_RST; yrl = YAW_RATE_LIMIT_RST; hold = 0; cnt = 6;
      end
      1: begin
        spd = 32'h7fffffff; tol = 30000; pg = 65535; yg = 65535; yrl = 32767;
        hold = 0; cnt = 16;
      end
      2: begin
        spd = 0; tol = 0; pg = 0; yg = 0; yrl = 0; hold = 1; cnt = 0;
      end
      3: begin
        spd = 40000; tol = 20000; pg = 300; yg = 100; yrl = 2000; hold = 1; cnt = 40;
      end
      4: begin
        spd = $urandom_range(0, 32'h7fffffff); tol = 32'h7fffffff;
        pg = $urandom_range(0, 65535); yg = $urandom_range(0, 65535);
        yrl = $urandom_range(0, 32767); hold = 0; cnt = 100;
      end
      default: begin
        spd = $urandom_range(0, 200000); tol = $urandom_range(1000, 60000);
        pg = $urandom_range(0, 2000); yg = $urandom_range(0, 65535);
        yrl = $urandom_range(0, 32767); hold = $urandom_range(1); cnt = $urandom_range(1, 127);
      end
    endcase
    wait_idle();
    write_reg(CFG_SPEED_LIMIT, spd);
    write_reg(CFG_REACH_TOL, tol);
    write_reg(CFG_POSITION_GAIN, pg);
    write_reg(CFG_YAW_GAIN, yg);
    write_reg(CFG_YAW_RATE_LIMIT, yrl);
    write_reg(CFG_HOLD_HEADING, hold);
    write_reg(CFG_WAYPOINT_COUNT, cnt);
    cfg_valid <= 1'b0;
    tol_now = int'(tol[30:0]);
    cnt_now = int'(cnt[6:0]);
    for (int s = 0; s < (cnt_now > 64 ? 64 : cnt_now); s++)
      if (!loaded[s] || $urandom_range(9) < 3) load_chain(s);
  endtask

  initial begin
    for (int s = 0; s < 64; s++) loaded[s] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load(0, 0, 0, 0);
    load(1, 300000, 0, 0);
    load(2, 300000, 300000, -65536);
    load(62, 32'h80000000, 32'h7fffffff, 32'h80000000);
    load(63, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    tick(0, 0, 0, 0);
    tick(0, 0, 0, 0);
    tick(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fff);
    tick(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h8000);

    for (int ph = 0; ph < 6; ph++) begin
      apply_setting(ph);
      repeat (310) begin
        if (n_rand < 620) begin
          snd_idle = 8; rcv_idle = 64;
        end else if (n_rand < 1240) begin
          snd_idle = 64; rcv_idle = 8;
        end else begin
          snd_idle = 0; rcv_idle = 0;
        end
        random_item();
        n_rand++;
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("waypoint_velocity_guidance regression: pass");
    end else begin
      $display("waypoint_velocity_guidance regression: fail");
    end
    $finish;
  end

endmodule
